>>> hdl/lptcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lptcf_pkg
// Shared types, register indexes and the arctangent step table for the
// lidar point transform and crop filter.
// ----------------------------------------------------------------------------
package lptcf_pkg;

	localparam int CFG_W     = 60;
	localparam int CFG_IDX_W = 3;
	localparam int ROT_W     = 16;
	localparam int TR_W      = 20;
	localparam int HGT_W     = 24;
	localparam int DST_W     = 20;
	localparam int FOV_W     = 16;
	localparam int ATTR_W    = 32;
	localparam int ANG_SHIFT = 24;
	localparam int ACC_W     = 26;
	localparam int ATAN_W    = 22;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT0   = 3'd0,
		REG_ROT1   = 3'd1,
		REG_ROT2   = 3'd2,
		REG_TRANS  = 3'd3,
		REG_HEIGHT = 3'd4,
		REG_DIST   = 3'd5,
		REG_FOV    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

	// atan(2^-i) in units of pi/2^23
	function automatic logic [ATAN_W-1:0] atan_step(input int i);
		logic [ATAN_W-1:0] r;
		unique case (i)
			0: r = 22'd2097152;
			1: r = 22'd1238021;
			2: r = 22'd654136;
			3: r = 22'd332050;
			4: r = 22'd166669;
			5: r = 22'd83416;
			6: r = 22'd41718;
			7: r = 22'd20860;
			8: r = 22'd10430;
			9: r = 22'd5215;
			10: r = 22'd2608;
			11: r = 22'd1304;
			12: r = 22'd652;
			13: r = 22'd326;
			14: r = 22'd163;
			15: r = 22'd81;
			16: r = 22'd41;
			17: r = 22'd20;
			18: r = 22'd10;
			19: r = 22'd5;
			20: r = 22'd3;
			21: r = 22'd1;
			22: r = 22'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/lptcf_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lptcf_cordic
// Pipelined CORDIC azimuth: quarter-turn pre-rotation, one vectoring step per
// stage, then rounding to pi/32768 units. Carries a sideband alongside.
// ----------------------------------------------------------------------------
module lptcf_cordic #(
	parameter int COORD_BITS = 24,
	parameter int ITERATIONS = 16,
	parameter int SIDE_W     = 105
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  lptcf_pkg::pipe_ctl_t          ctl,
	input  wire signed [COORD_BITS-1:0]   x,
	input  wire signed [COORD_BITS-1:0]   y,
	input  wire        [SIDE_W-1:0]       side_in,
	output logic                          vld_out,
	output logic signed [lptcf_pkg::FOV_W-1:0] ang,
	output logic       [SIDE_W-1:0]       side_out
);

	localparam int AW = COORD_BITS + lptcf_pkg::ANG_SHIFT + 3;
	localparam int CW = lptcf_pkg::ACC_W;

	logic signed [AW-1:0] cx_s   [0:ITERATIONS];
	logic signed [AW-1:0] cy_s   [0:ITERATIONS];
	logic signed [CW-1:0] acc_s  [0:ITERATIONS];
	logic                 zero_s [0:ITERATIONS];
	logic                 vld_s  [0:ITERATIONS];
	logic [SIDE_W-1:0]    side_s [0:ITERATIONS];

	logic signed [AW-1:0] xs, ys;
	assign xs = AW'(x) <<< lptcf_pkg::ANG_SHIFT;
	assign ys = AW'(y) <<< lptcf_pkg::ANG_SHIFT;

	// Pre-rotation into the right half-plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (ctl.en) begin
			vld_s[0] <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			side_s[0] <= side_in;
			zero_s[0] <= (x == '0) && (y == '0);
			if (x < 0) begin
				if (y >= 0) begin
					cx_s[0]  <= ys;
					cy_s[0]  <= -xs;
					acc_s[0] <= CW'(4194304);
				end else begin
					cx_s[0]  <= -ys;
					cy_s[0]  <= xs;
					acc_s[0] <= -CW'(4194304);
				end
			end else begin
				cx_s[0]  <= xs;
				cy_s[0]  <= ys;
				acc_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_step
		logic signed [AW-1:0] dx, dy;
		logic signed [CW-1:0] at;
		assign dx = cy_s[k] >>> k;
		assign dy = cx_s[k] >>> k;
		assign at = CW'(lptcf_pkg::atan_step(k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				side_s[k+1] <= side_s[k];
				zero_s[k+1] <= zero_s[k];
				if (cy_s[k] >= 0) begin
					cx_s[k+1]  <= cx_s[k] + dx;
					cy_s[k+1]  <= cy_s[k] - dy;
					acc_s[k+1] <= acc_s[k] + at;
				end else begin
					cx_s[k+1]  <= cx_s[k] - dx;
					cy_s[k+1]  <= cy_s[k] + dy;
					acc_s[k+1] <= acc_s[k] - at;
				end
			end
		end
	end

	// Round half up to pi/32768 and clamp
	logic signed [CW-1:0] rnd;
	assign rnd = (acc_s[ITERATIONS] + CW'(128)) >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (ctl.en) begin
			vld_out <= vld_s[ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			side_out <= side_s[ITERATIONS];
			if (zero_s[ITERATIONS]) begin
				ang <= '0;
			end else if (rnd > CW'(32767)) begin
				ang <= 16'sh7fff;
			end else if (rnd < -CW'(32768)) begin
				ang <= 16'sh8000;
			end else begin
				ang <= rnd[lptcf_pkg::FOV_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/lidar_point_transform_crop_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_point_transform_crop_filter
// Rigid transform of lidar points followed by height, distance and azimuth
// windows.
// ----------------------------------------------------------------------------
// One point request per clock whenever s_tready is high. Stages from
// s_tvalid/s_tready to m_tvalid: rotation products, sum/round/saturate,
// squares and height test, distance test, CORDIC pre-rotation, one CORDIC
// step per iteration, rounding of the angle, and the output register where
// the field-of-view test is folded in.
// The whole pipe advances together whenever the output register is empty or
// being drained, so s_tready drops only while a result sits unclaimed.
// Every point comes out; m_tuser (keep) says whether it passed all windows.
// Configuration writes take effect at once and should be made while idle.
// ----------------------------------------------------------------------------
module lidar_point_transform_crop_filter #(
	parameter int COORD_BITS        = 24,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  wire clk,
	input  wire arst_n,
	// x_in, y_in, z_in, attr_in (lowest first), zero padded to bytes
	input  wire [((3*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire                                 s_tlast,   // frame_last_in
	// x_out, y_out, z_out, attr_out (lowest first), zero padded to bytes
	output logic [((3*COORD_BITS+32+7)/8)*8-1:0] m_tdata,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic                                 m_tlast,   // frame_last_out
	output logic [0:0]                           m_tuser,   // keep
	input  wire                                  cfg_we,
	input  wire [lptcf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [lptcf_pkg::CFG_W-1:0]           cfg_data
);

	localparam int CB     = COORD_BITS;
	localparam int DATA_W = ((3*CB+32+7)/8)*8;
	localparam int PW     = CB + lptcf_pkg::ROT_W;
	localparam int SW     = CB + lptcf_pkg::ROT_W + 19;
	localparam int D2_W   = (2*CB+1 > 40) ? 2*CB+1 : 40;
	localparam int SIDE_W = 3*CB + lptcf_pkg::ATTR_W + 2;

	// ---------------------------------------------------------------- config
	logic [47:0] rot_q [3];
	logic [59:0] trans_q;
	logic [47:0] height_q;
	logic [39:0] dist_q;
	logic [31:0] fov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= 48'h4000_0000_0000;
			rot_q[1] <= 48'h0000_4000_0000;
			rot_q[2] <= 48'h0000_0000_4000;
			trans_q  <= '0;
			height_q <= 48'h8000_007f_ffff;
			dist_q   <= 40'h00000_fffff;
			fov_q    <= 32'h8000_7fff;
		end else if (cfg_we) begin
			unique case (lptcf_pkg::cfg_reg_t'(cfg_index))
				lptcf_pkg::REG_ROT0:   rot_q[0] <= cfg_data[47:0];
				lptcf_pkg::REG_ROT1:   rot_q[1] <= cfg_data[47:0];
				lptcf_pkg::REG_ROT2:   rot_q[2] <= cfg_data[47:0];
				lptcf_pkg::REG_TRANS:  trans_q  <= cfg_data[59:0];
				lptcf_pkg::REG_HEIGHT: height_q <= cfg_data[47:0];
				lptcf_pkg::REG_DIST:   dist_q   <= cfg_data[39:0];
				lptcf_pkg::REG_FOV:    fov_q    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic signed [lptcf_pkg::TR_W-1:0] tr [3];
	assign tr[0] = trans_q[59:40];
	assign tr[1] = trans_q[39:20];
	assign tr[2] = trans_q[19:0];

	logic signed [lptcf_pkg::HGT_W-1:0] zmin, zmax;
	logic signed [lptcf_pkg::FOV_W-1:0] fmin, fmax;
	assign zmin = height_q[47:24];
	assign zmax = height_q[23:0];
	assign fmin = fov_q[31:16];
	assign fmax = fov_q[15:0];

	// ------------------------------------------------------------ flow ctl
	// Single pipe enable: everything shifts while the output can move.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// -------------------------------------------------- stage 1: products
	logic signed [CB-1:0] cin [3];
	assign cin[0] = s_tdata[CB-1:0];
	assign cin[1] = s_tdata[2*CB-1:CB];
	assign cin[2] = s_tdata[3*CB-1:2*CB];

	logic signed [PW-1:0] p_s1 [3][3];
	logic [lptcf_pkg::ATTR_W-1:0] attr_s1;
	logic last_s1, vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			attr_s1 <= s_tdata[3*CB+31:3*CB];
			last_s1 <= s_tlast;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					p_s1[r][c] <= $signed(rot_q[r][47-16*c -: 16]) * cin[c];
				end
			end
		end
	end

	// ------------------------------- stage 2: sum, translate, round, clamp
	logic signed [SW-1:0] sum [3];
	logic signed [CB-1:0] sat [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = SW'(p_s1[r][0]) + SW'(p_s1[r][1]) + SW'(p_s1[r][2])
			       + (SW'(tr[r]) <<< 14) + SW'(8192);
			// result is sum[SW-1:14]; in range when the top bits agree
			if ((sum[r][SW-1:14+CB-1] == '0) || (sum[r][SW-1:14+CB-1] == '1)) begin
				sat[r] = sum[r][14+CB-1:14];
			end else if (sum[r][SW-1]) begin
				sat[r] = {1'b1, {(CB-1){1'b0}}};
			end else begin
				sat[r] = {1'b0, {(CB-1){1'b1}}};
			end
		end
	end

	logic signed [CB-1:0] c_s2 [3];
	logic [lptcf_pkg::ATTR_W-1:0] attr_s2;
	logic last_s2, vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2    <= sat;
			attr_s2 <= attr_s1;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------ stage 3: squares, height window
	logic [CB-1:0] ax, ay;
	assign ax = c_s2[0][CB-1] ? CB'(-c_s2[0]) : CB'(c_s2[0]);
	assign ay = c_s2[1][CB-1] ? CB'(-c_s2[1]) : CB'(c_s2[1]);

	logic [2*CB-1:0] sqx_s3, sqy_s3;
	logic [39:0] dmin2_s3, dmax2_s3;
	logic signed [CB-1:0] c_s3 [3];
	logic [lptcf_pkg::ATTR_W-1:0] attr_s3;
	logic last_s3, vld_s3, hok_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3   <= ax * ax;
			sqy_s3   <= ay * ay;
			dmin2_s3 <= dist_q[39:20] * dist_q[39:20];
			dmax2_s3 <= dist_q[19:0] * dist_q[19:0];
			hok_s3   <= (33'(c_s2[2]) >= 33'(zmin)) && (33'(c_s2[2]) <= 33'(zmax));
			c_s3     <= c_s2;
			attr_s3  <= attr_s2;
			last_s3  <= last_s2;
		end
	end

	// ------------------------------------------- stage 4: distance window
	logic [D2_W-1:0] d2;
	assign d2 = D2_W'(sqx_s3) + D2_W'(sqy_s3);

	logic signed [CB-1:0] c_s4 [3];
	logic [lptcf_pkg::ATTR_W-1:0] attr_s4;
	logic last_s4, vld_s4, ok_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4   <= hok_s3 && (d2 >= D2_W'(dmin2_s3)) && (d2 <= D2_W'(dmax2_s3));
			c_s4    <= c_s3;
			attr_s4 <= attr_s3;
			last_s4 <= last_s3;
		end
	end

	// ------------------------------------------------- azimuth pipeline
	lptcf_pkg::pipe_ctl_t cctl;
	assign cctl.en  = en;
	assign cctl.vld = vld_s4;

	logic [SIDE_W-1:0] side_in, side_out;
	logic signed [lptcf_pkg::FOV_W-1:0] ang;
	logic cvld;

	assign side_in = {ok_s4, last_s4, attr_s4, c_s4[2], c_s4[1], c_s4[0]};

	lptcf_cordic #(
		.COORD_BITS(CB),
		.ITERATIONS(CORDIC_ITERATIONS),
		.SIDE_W    (SIDE_W)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cctl),
		.x       (c_s4[0]),
		.y       (c_s4[1]),
		.side_in (side_in),
		.vld_out (cvld),
		.ang     (ang),
		.side_out(side_out)
	);

	// ------------------------------------ output register, azimuth window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= cvld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata    <= DATA_W'(side_out[3*CB+lptcf_pkg::ATTR_W-1:0]);
			m_tlast    <= side_out[SIDE_W-2];
			m_tuser[0] <= side_out[SIDE_W-1] && (ang >= fmin) && (ang <= fmax);
		end
	end

`ifndef SYNTHESIS
	// a kept point lies inside the height window
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |->
		((33'($signed(m_tdata[3*CB-1:2*CB])) >= 33'(zmin)) &&
		 (33'($signed(m_tdata[3*CB-1:2*CB])) <= 33'(zmax))))
		else $error("kept point outside height window");

	// a kept point at the origin needs zero azimuth inside the window
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] && (m_tdata[2*CB-1:0] == '0)) |->
		((fmin <= 0) && (fmax >= 0)))
		else $error("origin point kept outside field of view");

	// a point waiting at the output freezes the pipe
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(vld_s4) && $stable(cvld)))
		else $error("pipeline moved while output stalled");
`endif

endmodule
`default_nettype wire
